>>> design/bgg_pkg.sv
// ----------------------------------------------------------------------------
// bgg_pkg
// shared types, constants and helper functions of the bmp gray glyph stream
// ----------------------------------------------------------------------------
package bgg_pkg;

  // default limits and queue depth
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // file format constants
  localparam logic [7:0]  ASCII_B      = 8'h42;
  localparam logic [7:0]  ASCII_M      = 8'h4D;
  localparam logic [15:0] BPP_24       = 16'd24;
  localparam logic [15:0] BPP_32       = 16'd32;
  localparam logic [31:0] INFO_HDR_LEN = 32'd40;
  localparam logic [5:0]  HDR_LAST     = 6'd53;

  // result status codes
  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_BAD_SIG   = 2'd1,
    ST_BAD_DEPTH = 2'd2,
    ST_BAD_SIZE  = 2'd3
  } status_e;

  // one queued job between parser and shader
  typedef struct packed {
    status_e     status;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_in_row;
    logic        last_pixel;
    logic        all_gray;
  } job_t;

  // ramp " .:-=+*#%@"
  localparam logic [6:0] GLYPH_RAMP [10] = '{
    7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
  };

  // floor(sum / 3) for sum up to 765, via 683 / 2048
  function automatic logic [7:0] div3(input logic [9:0] sum);
    logic [20:0] prod;
    prod = 21'(sum) * 21'd683;
    return prod[18:11];
  endfunction

  // floor(gray * 9 / 255) as threshold compares
  function automatic logic [3:0] shade_index(input logic [7:0] gray);
    logic [3:0] idx;
    idx = 4'd0;
    if (gray >= 8'd29)  idx = 4'd1;
    if (gray >= 8'd57)  idx = 4'd2;
    if (gray >= 8'd85)  idx = 4'd3;
    if (gray >= 8'd114) idx = 4'd4;
    if (gray >= 8'd142) idx = 4'd5;
    if (gray >= 8'd170) idx = 4'd6;
    if (gray >= 8'd199) idx = 4'd7;
    if (gray >= 8'd227) idx = 4'd8;
    if (gray == 8'd255) idx = 4'd9;
    return idx;
  endfunction

endpackage

>>> design/bgg_parse.sv
// ----------------------------------------------------------------------------
// bgg_parse
// front end: walks header, skip, pixel and padding bytes and queues jobs
// ----------------------------------------------------------------------------
module bgg_parse #(
  parameter int unsigned MAX_WIDTH  = bgg_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bgg_pkg::DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output bgg_pkg::job_t push_data_o
);
  import bgg_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_PIXEL  = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [5:0]     hdr_cnt_q, hdr_cnt_d;
  logic [31:0]    hdr_len_q, hdr_len_d;
  logic [31:0]    width_q, width_d;
  logic [31:0]    height_q, height_d;
  logic           four_q, four_d;
  logic [31:0]    skip_q, skip_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [1:0]     bip_q, bip_d;
  logic [1:0]     pad_q, pad_d;
  logic [7:0]     blue_q, blue_d;
  logic [7:0]     green_q, green_d;
  logic           gray_ok_q, gray_ok_d;

  logic           accept;
  logic           col_last, row_last, pix_gray;
  logic [1:0]     pad_need, lane;
  logic [15:0]    bpp;
  logic [31:0]    col_ext, row_ext;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // end of row / end of image, from the validated sizes
  assign col_last = ({1'b0, col_q} + 1'b1) >= {1'b0, width_q[CW-1:0]};
  assign row_last = ({1'b0, row_q} + 1'b1) >= {1'b0, height_q[RW-1:0]};
  assign pad_need = four_q ? 2'd0 : width_q[1:0];
  assign pix_gray = (data_byte_i == green_q) && (green_q == blue_q);
  assign col_ext  = 32'(col_q);
  assign row_ext  = 32'(row_q);
  // byte lane of a little-endian header field, only used mid-header
  assign lane     = hdr_cnt_q[1:0] - 2'd2;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    hdr_len_d = hdr_len_q;
    width_d   = width_q;
    height_d  = height_q;
    four_d    = four_q;
    skip_d    = skip_q;
    col_d     = col_q;
    row_d     = row_q;
    bip_d     = bip_q;
    pad_d     = pad_q;
    blue_d    = blue_q;
    green_d   = green_q;
    gray_ok_d = gray_ok_q;
    bpp       = {green_q, blue_q};
    push_o      = 1'b0;
    push_data_o = '0;

    if (accept) begin
      if (first_byte_i) begin
        phase_d   = PH_HEADER;
        hdr_cnt_d = '0;
        hdr_len_d = '0;
        width_d   = '0;
        height_d  = '0;
        four_d    = 1'b0;
        skip_d    = '0;
        col_d     = '0;
        row_d     = '0;
        bip_d     = '0;
        pad_d     = '0;
        blue_d    = '0;
        green_d   = '0;
        gray_ok_d = 1'b1;
      end

      unique case (phase_d)
        PH_HEADER: begin
          if (hdr_cnt_d == 6'd1 && !(blue_d == ASCII_B && data_byte_i == ASCII_M)) begin
            push_o             = 1'b1;
            push_data_o.status = ST_BAD_SIG;
            phase_d            = PH_DONE;
          end else begin
            if (hdr_cnt_d == 6'd0) begin
              blue_d = data_byte_i;
            end else if (hdr_cnt_d >= 6'd14 && hdr_cnt_d <= 6'd17) begin
              hdr_len_d[{lane, 3'b000} +: 8] = data_byte_i;
            end else if (hdr_cnt_d >= 6'd18 && hdr_cnt_d <= 6'd21) begin
              width_d[{lane, 3'b000} +: 8] = data_byte_i;
            end else if (hdr_cnt_d >= 6'd22 && hdr_cnt_d <= 6'd25) begin
              height_d[{lane, 3'b000} +: 8] = data_byte_i;
            end else if (hdr_cnt_d == 6'd28) begin
              blue_d = data_byte_i;
            end else if (hdr_cnt_d == 6'd29) begin
              green_d = data_byte_i;
            end

            if (hdr_cnt_d < HDR_LAST) begin
              hdr_cnt_d = hdr_cnt_d + 6'd1;
            end else begin
              bpp     = {green_d, blue_d};
              blue_d  = '0;
              green_d = '0;
              if (bpp != BPP_24 && bpp != BPP_32) begin
                push_o             = 1'b1;
                push_data_o.status = ST_BAD_DEPTH;
                phase_d            = PH_DONE;
              end else begin
                four_d = (bpp == BPP_32);
                if (width_d[31] || width_d > 32'(MAX_WIDTH) ||
                    height_d[31] || height_d > 32'(MAX_HEIGHT)) begin
                  push_o             = 1'b1;
                  push_data_o.status = ST_BAD_SIZE;
                  phase_d            = PH_DONE;
                end else if (width_d == '0 || height_d == '0) begin
                  phase_d = PH_DONE;
                end else if (!hdr_len_d[31] && hdr_len_d > INFO_HDR_LEN) begin
                  skip_d  = hdr_len_d - INFO_HDR_LEN;
                  phase_d = PH_SKIP;
                end else begin
                  phase_d = PH_PIXEL;
                end
              end
            end
          end
        end

        PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == '0) begin
            phase_d = PH_PIXEL;
          end
        end

        PH_PIXEL: begin
          unique case (bip_q)
            2'd0: begin
              blue_d = data_byte_i;
              bip_d  = 2'd1;
            end
            2'd1: begin
              green_d = data_byte_i;
              bip_d   = 2'd2;
            end
            default: begin
              if (bip_q == 2'd2) begin
                gray_ok_d                = gray_ok_q && pix_gray;
                push_o                   = 1'b1;
                push_data_o.status       = ST_PIXEL;
                push_data_o.blue         = blue_q;
                push_data_o.green        = green_q;
                push_data_o.red          = data_byte_i;
                push_data_o.column       = col_ext[11:0];
                push_data_o.row          = row_ext[11:0];
                push_data_o.last_in_row  = col_last;
                push_data_o.last_pixel   = col_last && row_last;
                push_data_o.all_gray     = gray_ok_d;
              end
              if (bip_q == 2'd2 && four_q) begin
                bip_d = 2'd3;
              end else begin
                // pixel complete: next column, padding or next row
                bip_d = 2'd0;
                if (!col_last) begin
                  col_d = col_q + 1'b1;
                end else if (pad_need != 2'd0) begin
                  pad_d   = pad_need;
                  phase_d = PH_PAD;
                end else begin
                  col_d   = '0;
                  row_d   = row_q + 1'b1;
                  phase_d = row_last ? PH_DONE : PH_PIXEL;
                end
              end
            end
          endcase
        end

        PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) begin
            col_d   = '0;
            row_d   = row_q + 1'b1;
            phase_d = row_last ? PH_DONE : PH_PIXEL;
          end
        end

        PH_IDLE, PH_DONE: begin
          phase_d = phase_d;
        end

        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hdr_cnt_q <= '0;
      hdr_len_q <= '0;
      width_q   <= '0;
      height_q  <= '0;
      four_q    <= 1'b0;
      skip_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      bip_q     <= '0;
      pad_q     <= '0;
      blue_q    <= '0;
      green_q   <= '0;
      gray_ok_q <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      hdr_len_q <= hdr_len_d;
      width_q   <= width_d;
      height_q  <= height_d;
      four_q    <= four_d;
      skip_q    <= skip_d;
      col_q     <= col_d;
      row_q     <= row_d;
      bip_q     <= bip_d;
      pad_q     <= pad_d;
      blue_q    <= blue_d;
      green_q   <= green_d;
      gray_ok_q <= gray_ok_d;
    end
  end

endmodule

>>> design/bgg_queue.sv
// ----------------------------------------------------------------------------
// bgg_queue
// small job fifo between parser and shader
// ----------------------------------------------------------------------------
module bgg_queue #(
  parameter int unsigned DEPTH = bgg_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bgg_pkg::job_t push_data_i,
  output logic          full_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bgg_pkg::job_t pop_data_o
);
  import bgg_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;
  logic          pop;

  assign full_o      = (count_q == NW'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("queue count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

>>> design/bgg_shade.sv
// ----------------------------------------------------------------------------
// bgg_shade
// back end: gray average, then glyph lookup into the output register
// ----------------------------------------------------------------------------
module bgg_shade (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  bgg_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [7:0]    gray_o,
  output logic [6:0]    glyph_o,
  output logic [11:0]   column_o,
  output logic [11:0]   row_o,
  output logic          last_in_row_o,
  output logic          last_pixel_o,
  output logic          all_gray_o
);
  import bgg_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [7:0]  gray;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_in_row;
    logic        last_pixel;
    logic        all_gray;
  } shade_t;

  logic       s1_valid_q, s2_valid_q;
  shade_t     s1_q, s1_d, s2_q;
  logic [6:0] glyph_q, glyph_d;
  logic       s1_ready, s2_ready;
  logic [9:0] sum;

  assign s2_ready    = !s2_valid_q || out_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign job_ready_o = s1_ready;

  // stage 1: average of the three color bytes
  always_comb begin
    sum = 10'(job_i.blue) + 10'(job_i.green) + 10'(job_i.red);
    s1_d.status      = job_i.status;
    s1_d.gray        = (job_i.status == ST_PIXEL) ? div3(sum) : 8'd0;
    s1_d.column      = job_i.column;
    s1_d.row         = job_i.row;
    s1_d.last_in_row = job_i.last_in_row;
    s1_d.last_pixel  = job_i.last_pixel;
    s1_d.all_gray    = job_i.all_gray;
  end

  // stage 2: glyph from the ramp
  assign glyph_d = (s1_q.status == ST_PIXEL) ? GLYPH_RAMP[shade_index(s1_q.gray)] : 7'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= job_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && job_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q    <= s1_q;
      glyph_q <= glyph_d;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign status_o      = s2_q.status;
  assign gray_o        = s2_q.gray;
  assign glyph_o       = glyph_q;
  assign column_o      = s2_q.column;
  assign row_o         = s2_q.row;
  assign last_in_row_o = s2_q.last_in_row;
  assign last_pixel_o  = s2_q.last_pixel;
  assign all_gray_o    = s2_q.all_gray;

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.status != ST_PIXEL) |-> (gray_o == 8'd0 && glyph_o == 7'd0))
    else $error("error result carries pixel data");

  a_glyph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.status == ST_PIXEL) |-> (glyph_o >= 7'd32 && glyph_o <= 7'd64))
    else $error("glyph outside ramp");

  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> s2_valid_q)
    else $error("stage 1 result dropped");

endmodule

>>> design/bmp_to_gray_glyph_stream.sv
// ----------------------------------------------------------------------------
// bmp_to_gray_glyph_stream
// byte-wide bmp decoder giving one gray level and ascii glyph per pixel
// ----------------------------------------------------------------------------
// The block takes a 24- or 32-bit BMP file one byte per transaction, with
// first_byte_i marking the start of each file (it restarts the parser at any
// point). It accepts one byte every cycle while its job queue has room; a
// stalled output only holds the input back once the queue and the two
// shader stages are full. A pixel result passes from the queue through the
// stage 1 and stage 2 registers to the outputs; results come at most one per
// byte, so when unstalled the sustained rate is one byte per clock, set by the
// parser's single-byte state update. Errors (bad signature, unsupported
// depth, size out of range) give one result with every other field zero and
// end the file; a zero width or height gives no result. Bytes outside a file
// are dropped. column_o and row_o are the low twelve bits of the counters.
module bmp_to_gray_glyph_stream #(
  parameter int unsigned MAX_WIDTH   = bgg_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = bgg_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned QUEUE_DEPTH = bgg_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  gray_o,
  output logic [6:0]  glyph_o,
  output logic [11:0] column_o,
  output logic [11:0] row_o,
  output logic        last_in_row_o,
  output logic        last_pixel_o,
  output logic        all_gray_o
);
  import bgg_pkg::*;

  // parser to queue
  logic queue_full;
  logic push;
  job_t push_data;

  // queue to shader
  logic job_valid;
  logic job_ready;
  job_t job;

  // front end: header parsing, pixel assembly, row and padding walk
  bgg_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // decoupling queue so parser and shader stall independently
  bgg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_valid_o (job_valid),
    .pop_ready_i (job_ready),
    .pop_data_o  (job)
  );

  // back end: divide by three, ramp lookup, output register
  bgg_shade u_shade (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .job_i         (job),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .gray_o        (gray_o),
    .glyph_o       (glyph_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .last_in_row_o (last_in_row_o),
    .last_pixel_o  (last_pixel_o),
    .all_gray_o    (all_gray_o)
  );

endmodule

>>> dv/bmp_to_gray_glyph_stream_tb.sv
// ----------------------------------------------------------------------------
// bmp_to_gray_glyph_stream_tb
// self-checking bench: builds bmp files byte by byte, predicts every result
// ----------------------------------------------------------------------------
// A table of hand-picked files is sent first. It covers stray bytes, bad
// signatures, depths and sizes, empty images, header skips, restarts in the
// middle of a file, and the widest and tallest accepted sizes. Randomly
// shaped files follow: mostly well-formed, with some broken or cut short.
// Every accepted byte runs through a local decoder, which queues the results
// it expects. Results from the block are matched against that queue in order.
module bmp_to_gray_glyph_stream_tb;
  import bgg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned ITEM_BUDGET  = 1700;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_PRINTS   = 50;
  localparam int NUM_DIRECTED = 23;

  // byte offsets of the little-endian header fields
  localparam int OFS_HDR_LEN = 14;
  localparam int OFS_WIDTH   = 18;
  localparam int OFS_HEIGHT  = 22;
  localparam int OFS_DEPTH   = 28;

  localparam logic [15:0] SIG_OK     = {ASCII_B, ASCII_M};
  localparam logic [79:0] SHADE_RAMP = " .:-=+*#%@";

  typedef enum logic [2:0] {
    PARSE_IDLE, PARSE_HEADER, PARSE_SKIP, PARSE_PIXEL, PARSE_PAD, PARSE_DONE
  } parse_phase_e;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_GRAY, FILL_LEVEL} fill_mode_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  gray;
    logic [6:0]  glyph;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_in_row;
    logic        last_pixel;
    logic        all_gray;
  } glyph_result_t;

  // one file to send; want is nonzero only where the single result is typed in
  typedef struct {
    logic [15:0]   sig;
    logic [31:0]   hdr_len;
    logic [31:0]   width;
    logic [31:0]   height;
    logic [15:0]   bpp;
    fill_mode_e    fill;
    logic [7:0]    level;
    int            keep;
    int            lead;
    int            trail;
    glyph_result_t want;
  } bmp_case_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        first_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  gray_o;
  logic [6:0]  glyph_o;
  logic [11:0] column_o;
  logic [11:0] row_o;
  logic        last_in_row_o;
  logic        last_pixel_o;
  logic        all_gray_o;

  bmp_to_gray_glyph_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .gray_o        (gray_o),
    .glyph_o       (glyph_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .last_in_row_o (last_in_row_o),
    .last_pixel_o  (last_pixel_o),
    .all_gray_o    (all_gray_o)
  );

  always #2 clk_i = ~clk_i;

  // bench state
  int unsigned   cycle_cnt = 0;
  int unsigned   fail_count = 0;
  int unsigned   res_cnt = 0;
  int unsigned   sent_bytes = 0;
  bit            steady = 1'b0;
  bit            typed_pending = 1'b0;
  glyph_result_t typed_want;
  glyph_result_t glyph_q [$];
  logic [7:0]    bmp_bytes [$];
  bmp_case_t     dir_tbl [NUM_DIRECTED];

  // decoder state, a single copy that restarts with each file
  parse_phase_e ph = PARSE_IDLE;
  logic [5:0]   hdr_pos;
  logic [31:0]  info_size, px_width, px_height, skip_cnt;
  logic [31:0]  col_pos, row_pos;
  logic         alpha_on;
  logic [1:0]   chan_pos, pad_cnt;
  logic [7:0]   held_b, held_g;
  logic         gray_run;

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d, result %0d: %s", cycle_cnt, res_cnt, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  function automatic glyph_result_t err_only(input status_e s);
    glyph_result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // decoder: walks the same byte stream as the block
  // --------------------------------------------------------------------------
  task automatic restart_file();
    hdr_pos = '0; info_size = '0; px_width = '0; px_height = '0;
    skip_cnt = '0; col_pos = '0; row_pos = '0; alpha_on = 1'b0;
    chan_pos = '0; pad_cnt = '0; held_b = '0; held_g = '0;
    gray_run = 1'b1;
  endtask

  // a typed-in result from the table takes the place of the decoded one
  task automatic post_result(input glyph_result_t r);
    if (typed_pending) begin
      glyph_q.push_back(typed_want);
      typed_pending = 1'b0;
    end else begin
      glyph_q.push_back(r);
    end
  endtask

  task automatic post_error(input status_e s);
    post_result(err_only(s));
    ph = PARSE_DONE;
  endtask

  task automatic finish_row();
    col_pos = '0;
    row_pos++;
    ph = (row_pos >= px_height) ? PARSE_DONE : PARSE_PIXEL;
  endtask

  task automatic close_pixel();
    chan_pos = '0;
    if (col_pos + 1 < px_width) begin
      col_pos++;
    end else begin
      // 24-bit rows pad to four bytes: width mod 4 bytes of padding
      pad_cnt = alpha_on ? 2'd0 : px_width[1:0];
      if (pad_cnt != 0) ph = PARSE_PAD;
      else finish_row();
    end
  endtask

  task automatic decode_bmp_byte(input logic [7:0] b, input logic first);
    logic [15:0]   depth;
    logic [31:0]   sum_v;
    logic [7:0]    g, ch;
    int            idx;
    glyph_result_t r;
    if (first) begin
      restart_file();
      ph = PARSE_HEADER;
    end
    case (ph)
      PARSE_HEADER: begin
        if (hdr_pos == 0) begin
          held_b = b;
        end else if (hdr_pos == 1) begin
          if (held_b != ASCII_B || b != ASCII_M) begin
            post_error(ST_BAD_SIG);
            return;
          end
        end else if (hdr_pos >= OFS_HDR_LEN && hdr_pos < OFS_HDR_LEN + 4) begin
          info_size |= 32'(b) << (8 * (hdr_pos - OFS_HDR_LEN));
        end else if (hdr_pos >= OFS_WIDTH && hdr_pos < OFS_WIDTH + 4) begin
          px_width |= 32'(b) << (8 * (hdr_pos - OFS_WIDTH));
        end else if (hdr_pos >= OFS_HEIGHT && hdr_pos < OFS_HEIGHT + 4) begin
          px_height |= 32'(b) << (8 * (hdr_pos - OFS_HEIGHT));
        end else if (hdr_pos == OFS_DEPTH) begin
          held_b = b;
        end else if (hdr_pos == OFS_DEPTH + 1) begin
          held_g = b;
        end
        if (hdr_pos < HDR_LAST) begin
          hdr_pos++;
          return;
        end
        // last info header byte: depth first, then size
        depth = {held_g, held_b};
        held_b = '0;
        held_g = '0;
        if (depth == BPP_24) begin
          alpha_on = 1'b0;
        end else if (depth == BPP_32) begin
          alpha_on = 1'b1;
        end else begin
          post_error(ST_BAD_DEPTH);
          return;
        end
        if (px_width[31] || px_width > DEF_MAX_WIDTH ||
            px_height[31] || px_height > DEF_MAX_HEIGHT) begin
          post_error(ST_BAD_SIZE);
          return;
        end
        if (px_width == 0 || px_height == 0) begin
          ph = PARSE_DONE;
          return;
        end
        // header size is signed; only sizes above the info header skip
        if (!info_size[31] && info_size > INFO_HDR_LEN) begin
          skip_cnt = info_size - INFO_HDR_LEN;
          ph = PARSE_SKIP;
        end else begin
          ph = PARSE_PIXEL;
        end
      end
      PARSE_SKIP: begin
        skip_cnt--;
        if (skip_cnt == 0) ph = PARSE_PIXEL;
      end
      PARSE_PIXEL: begin
        case (chan_pos)
          2'd0: begin
            held_b = b;
            chan_pos = 2'd1;
          end
          2'd1: begin
            held_g = b;
            chan_pos = 2'd2;
          end
          2'd3: close_pixel();  // alpha byte
          default: begin
            if (b != held_g || held_g != held_b) gray_run = 1'b0;
            sum_v = 32'(held_b) + 32'(held_g) + 32'(b);
            g = 8'(sum_v / 3);
            idx = (int'(g) * 9) / 255;
            ch = SHADE_RAMP[8 * (9 - idx) +: 8];
            r.status = ST_PIXEL;
            r.gray = g;
            r.glyph = ch[6:0];
            r.column = col_pos[11:0];
            r.row = row_pos[11:0];
            r.last_in_row = (col_pos + 1 >= px_width);
            r.last_pixel = r.last_in_row && (row_pos + 1 >= px_height);
            r.all_gray = gray_run;
            post_result(r);
            if (alpha_on) chan_pos = 2'd3;
            else close_pixel();
          end
        endcase
      end
      PARSE_PAD: begin
        pad_cnt--;
        if (pad_cnt == 0) finish_row();
      end
      default: ;  // idle or done: stray byte
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic build_bmp(input bmp_case_t c);
    logic [7:0] v, bl, gr, rd;
    logic       ok;
    int         k, py, px;
    bmp_bytes.delete();
    bmp_bytes.push_back(c.sig[15:8]);
    bmp_bytes.push_back(c.sig[7:0]);
    while (bmp_bytes.size() < OFS_HDR_LEN) bmp_bytes.push_back(8'($urandom));
    for (k = 0; k < 4; k++) bmp_bytes.push_back(c.hdr_len[8*k +: 8]);
    for (k = 0; k < 4; k++) bmp_bytes.push_back(c.width[8*k +: 8]);
    for (k = 0; k < 4; k++) bmp_bytes.push_back(c.height[8*k +: 8]);
    while (bmp_bytes.size() < OFS_DEPTH) bmp_bytes.push_back(8'($urandom));
    bmp_bytes.push_back(c.bpp[7:0]);
    bmp_bytes.push_back(c.bpp[15:8]);
    while (bmp_bytes.size() <= HDR_LAST) bmp_bytes.push_back(8'($urandom));
    ok = (c.sig == SIG_OK) && (c.bpp == BPP_24 || c.bpp == BPP_32) &&
         !c.width[31] && c.width <= DEF_MAX_WIDTH && c.width != 0 &&
         !c.height[31] && c.height <= DEF_MAX_HEIGHT && c.height != 0;
    if (ok) begin
      if (!c.hdr_len[31] && c.hdr_len > INFO_HDR_LEN) begin
        repeat (c.hdr_len - INFO_HDR_LEN) bmp_bytes.push_back(8'($urandom));
      end
      for (py = 0; py < c.height; py++) begin
        for (px = 0; px < c.width; px++) begin
          v = 8'($urandom);
          case (c.fill)
            FILL_LEVEL: {bl, gr, rd} = {3{c.level}};
            FILL_GRAY: begin
              // mostly equal channels, now and then one off
              {bl, gr, rd} = {3{v}};
              if ($urandom_range(0, 15) == 0) rd = 8'($urandom);
            end
            default: {bl, gr, rd} = 24'($urandom);
          endcase
          bmp_bytes.push_back(bl);
          bmp_bytes.push_back(gr);
          bmp_bytes.push_back(rd);
          if (c.bpp == BPP_32) bmp_bytes.push_back(8'($urandom));
        end
        if (c.bpp == BPP_24) repeat (c.width[1:0]) bmp_bytes.push_back(8'($urandom));
      end
    end
    // cut short: the next file's first byte restarts the parser
    if (c.keep > 0 && c.keep < bmp_bytes.size()) bmp_bytes = bmp_bytes[0:c.keep-1];
  endtask

  // one input transaction; valid stays up when the next byte follows at once
  task automatic feed_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    first_byte_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    sent_bytes++;
    decode_bmp_byte(b, first);
  endtask

  task automatic send_case(input bmp_case_t c);
    build_bmp(c);
    if (c.want != '0) begin
      typed_pending = 1'b1;
      typed_want = c.want;
    end
    repeat (c.lead) feed_byte(8'($urandom), 1'b0);
    foreach (bmp_bytes[i]) feed_byte(bmp_bytes[i], i == 0);
    repeat (c.trail) feed_byte(8'($urandom), 1'b0);
  endtask

  function automatic bmp_case_t random_case();
    bmp_case_t   c;
    logic [31:0] big;
    c.sig = SIG_OK;
    c.hdr_len = INFO_HDR_LEN;
    c.width = $urandom_range(1, 7);
    if ($urandom_range(0, 9) == 0) c.width = $urandom_range(8, 20);
    c.height = $urandom_range(1, 4);
    c.bpp = $urandom_range(0, 1) ? BPP_32 : BPP_24;
    c.fill = fill_mode_e'($urandom_range(0, 1));
    c.level = 8'($urandom);
    c.keep = 0;
    c.lead = 0;
    c.trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    c.want = '0;
    // header size: plain, a short skip, small or negative
    case ($urandom_range(0, 4))
      3: c.hdr_len = $urandom_range(41, 47);
      4: c.hdr_len = $urandom_range(0, 1) ? {1'b1, 31'($urandom)} : $urandom_range(0, 39);
      default: ;
    endcase
    big = $urandom_range(0, 1) ? {1'b1, 31'($urandom)}
                               : $urandom_range(DEF_MAX_WIDTH + 1, 200000);
    case ($urandom_range(0, 9))
      0: begin
        c.sig = $urandom_range(0, 1) ? {ASCII_B, 8'($urandom)} : {8'($urandom), ASCII_M};
        if (c.sig == SIG_OK) c.sig ^= 16'h0001;
      end
      1: begin
        c.bpp = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (c.bpp == BPP_24 || c.bpp == BPP_32) c.bpp ^= 16'h0001;
      end
      2: begin
        if ($urandom_range(0, 1)) c.width = big;
        else c.height = big;
      end
      3: begin
        if ($urandom_range(0, 1)) c.width = '0;
        else c.height = '0;
      end
      4: c.keep = $urandom_range(1, 120);
      default: ;
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls, then compare with the oldest prediction
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    glyph_result_t want;
    int            stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      res_cnt++;
      if (glyph_q.size() == 0) begin
        note_mismatch("result with nothing pending");
      end else begin
        want = glyph_q.pop_front();
        compare_field("status", status_o, want.status);
        compare_field("gray", gray_o, want.gray);
        compare_field("glyph", glyph_o, want.glyph);
        compare_field("column", column_o, want.column);
        compare_field("row", row_o, want.row);
        compare_field("last_in_row", last_in_row_o, want.last_in_row);
        compare_field("last_pixel", last_pixel_o, want.last_pixel);
        compare_field("all_gray", all_gray_o, want.all_gray);
      end
    end
  end

  // hard stop on a hang
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    bmp_case_t c;
    restart_file();
    ph = PARSE_IDLE;

    // sig, hdr_len, width, height, bpp, fill, level, keep, lead, trail, want
    // stray bytes before any file, then a white pixel
    dir_tbl[0]  = '{SIG_OK, 40, 1, 1, BPP_24, FILL_LEVEL, 255, 0, 3, 2,
                    '{ST_PIXEL, 8'd255, 7'd64, 12'd0, 12'd0, 1'b1, 1'b1, 1'b1}};
    dir_tbl[1]  = '{SIG_OK, 40, 1, 1, BPP_32, FILL_LEVEL, 0, 0, 0, 0,
                    '{ST_PIXEL, 8'd0, 7'd32, 12'd0, 12'd0, 1'b1, 1'b1, 1'b1}};
    // bad signature, trailing bytes dropped
    dir_tbl[2]  = '{{ASCII_B, 8'h58}, 40, 1, 1, BPP_24, FILL_RANDOM, 0, 0, 0, 4,
                    err_only(ST_BAD_SIG)};
    dir_tbl[3]  = '{{8'h58, ASCII_M}, 40, 1, 1, BPP_24, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_SIG)};
    dir_tbl[4]  = '{SIG_OK, 40, 2, 2, 16'd16, FILL_RANDOM, 0, 0, 0, 3,
                    err_only(ST_BAD_DEPTH)};
    dir_tbl[5]  = '{SIG_OK, 40, 2, 2, 16'h0118, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_DEPTH)};
    // depth is judged before size
    dir_tbl[6]  = '{SIG_OK, 40, 32'hFFFF_FFFF, 2, 16'd8, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_DEPTH)};
    dir_tbl[7]  = '{SIG_OK, 40, 32'hFFFF_FFFF, 2, BPP_24, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_SIZE)};
    dir_tbl[8]  = '{SIG_OK, 40, 3, 32'h8000_0000, BPP_32, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_SIZE)};
    dir_tbl[9]  = '{SIG_OK, 40, 4097, 1, BPP_24, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_SIZE)};
    dir_tbl[10] = '{SIG_OK, 40, 1, 32'h0001_0000, BPP_24, FILL_RANDOM, 0, 0, 0, 0,
                    err_only(ST_BAD_SIZE)};
    // empty images give nothing
    dir_tbl[11] = '{SIG_OK, 40, 0, 3, BPP_24, FILL_RANDOM, 0, 0, 0, 5, '0};
    dir_tbl[12] = '{SIG_OK, 40, 5, 0, BPP_32, FILL_RANDOM, 0, 0, 0, 2, '0};
    // header sizes: skip, short, negative
    dir_tbl[13] = '{SIG_OK, 48, 3, 2, BPP_24, FILL_RANDOM, 0, 0, 0, 0, '0};
    dir_tbl[14] = '{SIG_OK, 12, 2, 2, BPP_32, FILL_RANDOM, 0, 0, 0, 0, '0};
    dir_tbl[15] = '{SIG_OK, 32'hFFFF_FFF0, 5, 2, BPP_24, FILL_GRAY, 0, 0, 0, 0, '0};
    // three pad bytes per row, stray bytes after the end
    dir_tbl[16] = '{SIG_OK, 40, 3, 2, BPP_24, FILL_RANDOM, 0, 0, 0, 3, '0};
    // restarts among pixels, inside the skip, on the second byte
    dir_tbl[17] = '{SIG_OK, 40, 6, 4, BPP_24, FILL_RANDOM, 0, 80, 0, 0, '0};
    dir_tbl[18] = '{SIG_OK, 60, 2, 2, BPP_24, FILL_RANDOM, 0, 58, 0, 0, '0};
    dir_tbl[19] = '{SIG_OK, 40, 2, 2, BPP_24, FILL_RANDOM, 0, 1, 0, 0, '0};
    // widest row, tallest image, cut short after a few pixels
    dir_tbl[20] = '{SIG_OK, 40, 4096, 1, BPP_32, FILL_GRAY, 0, 70, 0, 0, '0};
    dir_tbl[21] = '{SIG_OK, 40, 1, 4096, BPP_24, FILL_GRAY, 0, 70, 0, 0, '0};
    dir_tbl[22] = '{SIG_OK, 40, 4, 3, BPP_32, FILL_LEVEL, 128, 0, 0, 0, '0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      steady = ($urandom_range(0, 3) == 0);
      send_case(dir_tbl[i]);
    end

    while (sent_bytes < ITEM_BUDGET) begin
      c = random_case();
      steady = ($urandom_range(0, 4) == 0);
      send_case(c);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    // let the last results drain, then watch for extras
    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
